>>> hdl/unt_pkg.sv
// Package for the unique name table: operation and status codes, name sizes
// and the character helper. No dependencies.
`timescale 1ns / 1ps

package unt_pkg;

    localparam int NAME_BYTES = 30;
    localparam int NAME_W = 8 * NAME_BYTES;
    localparam int CAPACITY_DEFAULT = 64;
    localparam int NAME_CHARS_DEFAULT = 30;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_BAD_INDEX = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7a)
            return c - 8'h20;
        return c;
    endfunction

endpackage

>>> hdl/unt_prep.sv
// Name preparation for the unique name table: one byte per cycle, it builds the
// upper-cased name and the trimmed, space-collapsed name. Depends on unt_pkg.
`timescale 1ns / 1ps

module unt_prep #(
    parameter int NAME_CHARS = unt_pkg::NAME_CHARS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [unt_pkg::NAME_W-1:0] name,
    output logic                      done,
    output logic [unt_pkg::NAME_W-1:0] raw_name,
    output logic [unt_pkg::NAME_W-1:0] tidy_name
);
    import unt_pkg::*;

    logic [7:0] src_reg  [NAME_BYTES];
    logic [7:0] raw_reg  [NAME_BYTES];
    logic [7:0] tidy_reg [NAME_BYTES];
    logic [4:0] k_reg;
    logic [4:0] len_reg;
    logic       ended_reg;
    logic       gap_reg;
    logic       busy_reg;
    logic       done_reg;

    logic [7:0] c;
    logic [7:0] u;
    logic       e;
    logic       put_gap;
    logic [4:0] lp;

    always_comb
    begin
        c = src_reg[k_reg];
        u = to_upper(c);
        e = ended_reg || (c == 8'h00) || (32'(k_reg) >= NAME_CHARS);
        put_gap = gap_reg && (len_reg < 5'(NAME_BYTES));
        lp = len_reg + (put_gap ? 5'd1 : 5'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg <= '0;
            len_reg <= '0;
            ended_reg <= 1'b0;
            gap_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg <= '0;
                len_reg <= '0;
                ended_reg <= 1'b0;
                gap_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                ended_reg <= e;
                if (!e)
                begin
                    if (u == CHAR_SPACE)
                    begin
                        if (len_reg != 5'd0)
                            gap_reg <= 1'b1;
                    end
                    else
                    begin
                        gap_reg <= 1'b0;
                        len_reg <= (lp < 5'(NAME_BYTES)) ? lp + 5'd1 : lp;
                    end
                end
                if (k_reg == 5'(NAME_BYTES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    k_reg <= k_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int b = 0; b < NAME_BYTES; b++)
            begin
                src_reg[b] <= name[NAME_W-1-8*b -: 8];
                raw_reg[b] <= 8'h00;
                tidy_reg[b] <= 8'h00;
            end
        end
        else if (busy_reg && !e)
        begin
            raw_reg[k_reg] <= u;
            if (u != CHAR_SPACE)
            begin
                if (put_gap)
                    tidy_reg[len_reg] <= CHAR_SPACE;
                if (lp < 5'(NAME_BYTES))
                    tidy_reg[lp] <= u;
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            raw_name[NAME_W-1-8*b -: 8] = raw_reg[b];
            tidy_name[NAME_W-1-8*b -: 8] = tidy_reg[b];
        end
    end

    assign done = done_reg;

endmodule

>>> hdl/unique_name_table_top.sv
// Unique name table top level: sequencer, name store and shared comparator.
// Depends on unt_pkg and unt_prep.
// Add and search scan the stored names one by one, remove shifts the later
// entries down, list first sorts the table in place and then emits each
// listed item; all of these go through the single read port of the store.
// One item at a time; a new item is taken as soon as the sequencer is idle.
// Reset empties the table at once; store contents are not cleared.
`timescale 1ns / 1ps

module unique_name_table_top #(
    parameter int CAPACITY   = unt_pkg::CAPACITY_DEFAULT,
    parameter int NAME_CHARS = unt_pkg::NAME_CHARS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [63:0] name_word0,
    input  logic [63:0] name_word1,
    input  logic [63:0] name_word2,
    input  logic [47:0] name_word3,
    input  logic [5:0]  remove_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [5:0]  entry_index,
    output logic [63:0] out_word0,
    output logic [63:0] out_word1,
    output logic [63:0] out_word2,
    output logic [47:0] out_word3,
    output logic        last
);
    import unt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [12:0] {
        S_IDLE       = 13'b0000000000001,
        S_PREP       = 13'b0000000000010,
        S_FIND_RD    = 13'b0000000000100,
        S_FIND_CMP   = 13'b0000000001000,
        S_SHIFT_RD   = 13'b0000000010000,
        S_SHIFT_WR   = 13'b0000000100000,
        S_SORT_START = 13'b0000001000000,
        S_SORT_LOAD  = 13'b0000010000000,
        S_SORT_RD    = 13'b0000100000000,
        S_SORT_CMP   = 13'b0001000000000,
        S_LIST_RD    = 13'b0010000000000,
        S_LIST_LD    = 13'b0100000000000,
        S_EMIT       = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [NAME_W-1:0]   key_reg, key_next;
    logic [5:0]          ridx_reg, ridx_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [NAME_W-1:0]   carry_reg, carry_next;
    status_t             res_status_reg, res_status_next;
    logic [5:0]          res_idx_reg, res_idx_next;
    logic [NAME_W-1:0]   res_name_reg, res_name_next;
    logic                res_last_reg, res_last_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [5:0]          out_idx_reg, out_idx_next;
    logic [NAME_W-1:0]   out_name_reg, out_name_next;
    logic                out_last_reg, out_last_next;

    logic [NAME_W-1:0]   mem [CAPACITY];
    logic [NAME_W-1:0]   rd_data_reg;
    logic [AW-1:0]       ra;
    logic [AW-1:0]       wa;
    logic [NAME_W-1:0]   wd;
    logic                we;

    logic [NAME_W-1:0]   cmp_a, cmp_b;
    logic                cmp_eq, cmp_lt;
    logic [CW-1:0]       jm1, cm1;

    logic                accept;
    logic                prep_done;
    logic [NAME_W-1:0]   raw_name, tidy_name;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    unt_prep #(
        .NAME_CHARS(NAME_CHARS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .name      ({name_word0, name_word1, name_word2, name_word3}),
        .done      (prep_done),
        .raw_name  (raw_name),
        .tidy_name (tidy_name)
    );

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_data_reg <= mem[ra];
    end

    assign cmp_eq = (cmp_a == cmp_b);
    assign cmp_lt = (cmp_a < cmp_b);
    assign jm1 = j_reg - 1'b1;
    assign cm1 = cnt_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        key_next = key_reg;
        ridx_next = ridx_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        j_next = j_reg;
        carry_next = carry_reg;
        res_status_next = res_status_reg;
        res_idx_next = res_idx_reg;
        res_name_next = res_name_reg;
        res_last_next = res_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_idx_next = out_idx_reg;
        out_name_next = out_name_reg;
        out_last_next = out_last_reg;
        ra = i_reg[AW-1:0];
        wa = j_reg[AW-1:0];
        wd = carry_reg;
        we = 1'b0;
        cmp_a = rd_data_reg;
        cmp_b = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next = op_t'(operation);
                    ridx_next = remove_index;
                    res_last_next = 1'b1;
                    res_idx_next = '0;
                    res_name_next = '0;
                    state_next = S_EMIT;
                    if (op_t'(operation) == OP_ADD)
                    begin
                        if (cnt_reg >= CW'(CAPACITY))
                            res_status_next = ST_FULL;
                        else
                            state_next = S_PREP;
                    end
                    else if (cnt_reg == '0)
                        res_status_next = ST_EMPTY;
                    else if (op_t'(operation) == OP_REMOVE)
                    begin
                        if ({1'b0, remove_index} >= 7'(cnt_reg))
                            res_status_next = ST_BAD_INDEX;
                        else
                        begin
                            j_next = CW'(remove_index) + 1'b1;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    else if (op_t'(operation) == OP_SEARCH)
                        state_next = S_PREP;
                    else
                    begin
                        i_next = '0;
                        state_next = S_SORT_START;
                    end
                end
            end
            S_PREP:
            begin
                if (prep_done)
                begin
                    key_next = (op_reg == OP_ADD) ? tidy_name : raw_name;
                    i_next = '0;
                    state_next = S_FIND_RD;
                end
            end
            S_FIND_RD:
            begin
                if (i_reg == cnt_reg)
                begin
                    state_next = S_EMIT;
                    if (op_reg == OP_ADD)
                    begin
                        we = 1'b1;
                        wa = cnt_reg[AW-1:0];
                        wd = key_reg;
                        res_status_next = ST_OK;
                        res_idx_next = 6'(cnt_reg);
                        res_name_next = key_reg;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                        res_status_next = ST_NOT_FOUND;
                end
                else
                    state_next = S_FIND_CMP;
            end
            S_FIND_CMP:
            begin
                if (cmp_eq)
                begin
                    res_status_next = (op_reg == OP_ADD) ? ST_DUPLICATE : ST_OK;
                    res_idx_next = 6'(i_reg);
                    res_name_next = key_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_SHIFT_RD:
            begin
                ra = j_reg[AW-1:0];
                if (j_reg == cnt_reg)
                begin
                    cnt_next = cm1;
                    res_status_next = ST_OK;
                    res_idx_next = ridx_reg;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                we = 1'b1;
                wa = jm1[AW-1:0];
                wd = rd_data_reg;
                j_next = j_reg + 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_SORT_START:
            begin
                ra = cm1[AW-1:0];
                if ((i_reg + 1'b1) >= cnt_reg)
                begin
                    i_next = '0;
                    state_next = S_LIST_RD;
                end
                else
                begin
                    j_next = cm1;
                    state_next = S_SORT_LOAD;
                end
            end
            S_SORT_LOAD:
            begin
                carry_next = rd_data_reg;
                state_next = S_SORT_RD;
            end
            S_SORT_RD:
            begin
                ra = jm1[AW-1:0];
                if (j_reg == i_reg)
                begin
                    we = 1'b1;
                    wa = i_reg[AW-1:0];
                    wd = carry_reg;
                    i_next = i_reg + 1'b1;
                    state_next = S_SORT_START;
                end
                else
                    state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                cmp_a = carry_reg;
                cmp_b = rd_data_reg;
                we = 1'b1;
                wa = j_reg[AW-1:0];
                if (cmp_lt)
                    wd = rd_data_reg;
                else
                begin
                    wd = carry_reg;
                    carry_next = rd_data_reg;
                end
                j_next = jm1;
                state_next = S_SORT_RD;
            end
            S_LIST_RD:
            begin
                state_next = S_LIST_LD;
            end
            S_LIST_LD:
            begin
                res_status_next = ST_OK;
                res_idx_next = 6'(i_reg);
                res_name_next = rd_data_reg;
                res_last_next = ((i_reg + 1'b1) == cnt_reg);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_status_next = res_status_reg;
                    out_idx_next = res_idx_reg;
                    out_name_next = res_name_reg;
                    out_last_next = res_last_reg;
                    if (res_last_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = S_LIST_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        key_reg <= key_next;
        ridx_reg <= ridx_next;
        i_reg <= i_next;
        j_reg <= j_next;
        carry_reg <= carry_next;
        res_status_reg <= res_status_next;
        res_idx_reg <= res_idx_next;
        res_name_reg <= res_name_next;
        res_last_reg <= res_last_next;
        out_status_reg <= out_status_next;
        out_idx_reg <= out_idx_next;
        out_name_reg <= out_name_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign status = out_status_reg;
    assign entry_index = out_idx_reg;
    assign out_word0 = out_name_reg[239:176];
    assign out_word1 = out_name_reg[175:112];
    assign out_word2 = out_name_reg[111:48];
    assign out_word3 = out_name_reg[47:0];
    assign last = out_last_reg;

endmodule

>>> hdl/unt_checker.sv
// Port-level checks for the unique name table, bound to the top level.
// Depends on unt_pkg and unique_name_table_top.
`timescale 1ns / 1ps

module unt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [5:0]  entry_index,
    input logic [63:0] out_word0,
    input logic        last
);
    import unt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_index)
            && $stable(out_word0) && $stable(last))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after an item was taken");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 3'(ST_OK) |-> last)
        else $error("error result not marked last");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == 3'(ST_FULL) || status == 3'(ST_EMPTY)
            || status == 3'(ST_BAD_INDEX) || status == 3'(ST_NOT_FOUND))
        |-> entry_index == 6'd0 && out_word0 == 64'd0)
        else $error("error result carries data");

endmodule

bind unique_name_table_top unt_checker u_unt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_index (entry_index),
    .out_word0   (out_word0),
    .last        (last)
);

>>> test/tb.sv
// Testbench for unique_name_table_top: directed table of items, a fill to capacity, then random
// traffic; every result checked against an in-bench model of the name table. Depends on unt_pkg.
`timescale 1ns / 1ps

module tb;
    import unt_pkg::*;

    localparam int CAP = 64;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]  st;
        logic [5:0]  idx;
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [47:0] w3;
        logic        lst;
    } outcome_t;

    typedef struct {
        op_t          op;
        logic [239:0] name;
        logic [5:0]   ridx;
        bit           typed;
        outcome_t     res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] operation = '0;
    logic [63:0] name_word0 = '0;
    logic [63:0] name_word1 = '0;
    logic [63:0] name_word2 = '0;
    logic [47:0] name_word3 = '0;
    logic [5:0] remove_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic [5:0] entry_index;
    logic [63:0] out_word0;
    logic [63:0] out_word1;
    logic [63:0] out_word2;
    logic [47:0] out_word3;
    logic last;

    logic [239:0] names_held [CAP];
    int count_held = 0;
    outcome_t pending_results[$];
    int failures = 0;
    int idle_cycles = 0;
    bit sender_done = 1'b0;
    bit hold_receiver = 1'b0;
    bit no_idle = 1'b0;
    int stall_pct = 34;

    always #5 clk = ~clk;

    unique_name_table_top i_dut (.*);

    function automatic logic [239:0] clean_name(logic [239:0] n, bit trim);
        logic [7:0] c;
        logic [7:0] b [30];
        logic [239:0] r;
        bit ended;
        bit gap;
        int len;
        ended = 0;
        for (int k = 0; k < 30; k++)
        begin
            c = n[239 - 8 * k -: 8];
            if (c == 8'h00)
                ended = 1;
            if (ended)
                c = 8'h00;
            if (c >= "a" && c <= "z")
                c = c - 8'h20;
            b[k] = c;
        end
        r = '0;
        if (!trim)
        begin
            for (int k = 0; k < 30; k++)
                r[239 - 8 * k -: 8] = b[k];
            return r;
        end
        len = 0;
        gap = 0;
        for (int k = 0; k < 30 && b[k] != 8'h00; k++)
        begin
            if (b[k] == CHAR_SPACE)
            begin
                if (len > 0)
                    gap = 1;
            end
            else
            begin
                if (gap && len < 30)
                begin
                    r[239 - 8 * len -: 8] = CHAR_SPACE;
                    len++;
                end
                gap = 0;
                if (len < 30)
                begin
                    r[239 - 8 * len -: 8] = b[k];
                    len++;
                end
            end
        end
        return r;
    endfunction

    function automatic outcome_t make_outcome(status_t s, int i, logic [239:0] n, bit l);
        outcome_t o;
        o.st = s;
        o.idx = i[5:0];
        {o.w0, o.w1, o.w2, o.w3} = n;
        o.lst = l;
        return o;
    endfunction

    function automatic int locate_name(logic [239:0] n);
        for (int i = 0; i < count_held; i++)
            if (names_held[i] == n)
                return i;
        return -1;
    endfunction

    task automatic predict_table(op_t op, logic [239:0] raw, logic [5:0] ridx);
        logic [239:0] n;
        logic [239:0] t;
        int f;
        if (op == OP_ADD)
        begin
            if (count_held >= CAP)
                pending_results.push_back(make_outcome(ST_FULL, 0, '0, 1));
            else
            begin
                n = clean_name(raw, 1);
                f = locate_name(n);
                if (f >= 0)
                    pending_results.push_back(make_outcome(ST_DUPLICATE, f, n, 1));
                else
                begin
                    names_held[count_held] = n;
                    pending_results.push_back(make_outcome(ST_OK, count_held, n, 1));
                    count_held++;
                end
            end
        end
        else if (count_held == 0)
            pending_results.push_back(make_outcome(ST_EMPTY, 0, '0, 1));
        else if (op == OP_REMOVE)
        begin
            if (ridx >= count_held)
                pending_results.push_back(make_outcome(ST_BAD_INDEX, 0, '0, 1));
            else
            begin
                for (int j = ridx + 1; j < count_held; j++)
                    names_held[j - 1] = names_held[j];
                count_held--;
                pending_results.push_back(make_outcome(ST_OK, ridx, '0, 1));
            end
        end
        else if (op == OP_SEARCH)
        begin
            f = locate_name(clean_name(raw, 0));
            if (f < 0)
                pending_results.push_back(make_outcome(ST_NOT_FOUND, 0, '0, 1));
            else
                pending_results.push_back(make_outcome(ST_OK, f, names_held[f], 1));
        end
        else
        begin
            for (int i = 0; i + 1 < count_held; i++)
                for (int j = count_held - 1; j > i; j--)
                    if (names_held[j] < names_held[j - 1])
                    begin
                        t = names_held[j];
                        names_held[j] = names_held[j - 1];
                        names_held[j - 1] = t;
                    end
            for (int i = 0; i < count_held; i++)
                pending_results.push_back(make_outcome(ST_OK, i, names_held[i],
                                                       i + 1 == count_held));
        end
    endtask

    task automatic send_item(op_t op, logic [239:0] raw, logic [5:0] ridx);
        if (!no_idle && $urandom_range(99) < stall_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (!no_idle && $urandom_range(99) < stall_pct)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        {name_word0, name_word1, name_word2, name_word3} <= raw;
        remove_index <= ridx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_table(op, raw, ridx);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [239:0] text_name(string s);
        logic [239:0] r;
        r = '0;
        for (int k = 0; k < s.len() && k < 30; k++)
            r[239 - 8 * k -: 8] = s[k];
        return r;
    endfunction

    function automatic logic [239:0] random_name(bit messy);
        logic [239:0] r;
        int len;
        int pick;
        r = '0;
        if (messy)
        begin
            for (int k = 0; k < 30; k++)
                r[239 - 8 * k -: 8] = $urandom;
            return r;
        end
        len = $urandom_range(1, 30);
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(9);
            if (pick < 3)
                r[239 - 8 * k -: 8] = CHAR_SPACE;
            else if (pick < 6)
                r[239 - 8 * k -: 8] = "a" + $urandom_range(3);
            else
                r[239 - 8 * k -: 8] = "A" + $urandom_range(3);
        end
        return r;
    endfunction

    // Receiver: random back-pressure, plus a long forced hold during one phase.
    always @(negedge clk)
        out_ready <= !hold_receiver && (no_idle || $urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status, entry_index, out_word0, out_word1, out_word2, out_word3, last};
            if (pending_results.size() == 0)
            begin
                $error("unexpected result, status %0d", status);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.st !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, got.st);
                    failures++;
                end
                if (got.idx !== want.idx)
                begin
                    $error("entry_index: expected %0d, got %0d", want.idx, got.idx);
                    failures++;
                end
                if (got.w0 !== want.w0)
                begin
                    $error("out_word0: expected %h, got %h", want.w0, got.w0);
                    failures++;
                end
                if (got.w1 !== want.w1)
                begin
                    $error("out_word1: expected %h, got %h", want.w1, got.w1);
                    failures++;
                end
                if (got.w2 !== want.w2)
                begin
                    $error("out_word2: expected %h, got %h", want.w2, got.w2);
                    failures++;
                end
                if (got.w3 !== want.w3)
                begin
                    $error("out_word3: expected %h, got %h", want.w3, got.w3);
                    failures++;
                end
                if (got.lst !== want.lst)
                begin
                    $error("last: expected %0d, got %0d", want.lst, got.lst);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
        if (sender_done && pending_results.size() == 0)
        begin
            repeat (200) @(negedge clk);
            if (failures == 0 && pending_results.size() == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
            $finish;
        end

    row_t directed [$];

    initial
    begin
        row_t r;
        int pick;
        op_t op;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        r.typed = 1; r.ridx = 0; r.name = '0;
        r.op = OP_REMOVE; r.res = make_outcome(ST_EMPTY, 0, '0, 1); directed.push_back(r);
        r.op = OP_SEARCH; directed.push_back(r);
        r.op = OP_LIST; directed.push_back(r);
        r.op = OP_ADD; r.name = text_name("   ");
        r.res = make_outcome(ST_OK, 0, '0, 1); directed.push_back(r);
        r.typed = 0;
        r.name = text_name("  bob   smith  "); directed.push_back(r);
        r.name = text_name("BOB SMITH"); directed.push_back(r);
        r.name = {240{1'b1}}; directed.push_back(r);
        r.name = '0; directed.push_back(r);
        r.name = text_name("zed"); directed.push_back(r);
        r.name = {8'h61, 8'h00, 8'h62, {27{8'h63}}}; directed.push_back(r);
        r.name = text_name("abcdefghijklmnopqrstuvwxyzabcd"); directed.push_back(r);
        r.op = OP_SEARCH; r.name = text_name("bob smith"); directed.push_back(r);
        r.name = text_name(" bob smith"); directed.push_back(r);
        r.name = text_name("ZED"); directed.push_back(r);
        r.op = OP_REMOVE; r.ridx = 63; r.typed = 1;
        r.res = make_outcome(ST_BAD_INDEX, 0, '0, 1); directed.push_back(r);
        r.typed = 0; r.ridx = 1; directed.push_back(r);
        r.op = OP_LIST; directed.push_back(r);
        r.op = OP_REMOVE; r.ridx = 0; directed.push_back(r);
        r.op = OP_LIST; directed.push_back(r);

        foreach (directed[i])
        begin
            send_item(directed[i].op, directed[i].name, directed[i].ridx);
            if (directed[i].typed && pending_results[$] !== directed[i].res)
            begin
                $error("directed row %0d: model disagrees with typed result", i);
                failures++;
            end
        end
        wait_drained();

        // Fill to capacity with the receiver held off, so that the input stalls.
        hold_receiver = 1'b1;
        fork
            begin
                repeat (3000) @(negedge clk);
                hold_receiver = 1'b0;
            end
        join_none
        while (count_held < CAP)
            send_item(OP_ADD, 240'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom} & {30{8'h7f}}
                                   | {30{8'h01}}),
                       0);
        send_item(OP_ADD, text_name("x"), 0);
        send_item(OP_LIST, '0, 0);
        wait_drained();
        while (count_held > 5)
            send_item(OP_REMOVE, '0, 6'($urandom_range(count_held - 1)));
        wait_drained();

        no_idle = 1'b1;
        for (int n = 0; n < 325; n++)
        begin
            if (n == 150)
                no_idle = 1'b0;
            pick = $urandom_range(99);
            if (pick < 45) op = OP_ADD;
            else if (pick < 65) op = OP_REMOVE;
            else if (pick < 90) op = OP_SEARCH;
            else op = OP_LIST;
            if (op == OP_SEARCH && count_held > 0 && $urandom_range(1))
                send_item(op, names_held[$urandom_range(count_held - 1)], 0);
            else
                send_item(op, random_name($urandom_range(9) == 0),
                          (count_held > 0 && $urandom_range(3) != 0)
                              ? 6'($urandom_range(count_held - 1)) : 6'($urandom));
            if (n % 100 == 99)
                wait_drained();
        end
        in_valid <= 1'b0;
        sender_done = 1'b1;
    end
endmodule
